// ===== rtl/core/iog_pkg.sv =====
// Package for the interval overlap grouper.
// Holds the field and index widths shared by the sorter front end and the grouping back end.
// No dependencies.
`default_nettype none
package iog_pkg;
  localparam int unsigned FIELD_W = 40;
  localparam int unsigned IDX_W = 5;
endpackage
`default_nettype wire

// ===== rtl/core/iog_front.sv =====
// Front end: insertion-sorting chain that keeps the batch ordered by start time.
// Depends on iog_pkg. On the final word it hands the ordered list to the back end.
`default_nettype none
module iog_front #(
  parameter int unsigned MAX_JOBS = 32,
  parameter int unsigned TIME_BITS = 40
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 push,
  input  wire logic [TIME_BITS-1:0]                 s_in,
  input  wire logic [TIME_BITS-1:0]                 e_in,
  input  wire logic                                 last_in,
  input  wire logic                                 rd_en,
  input  wire logic [$clog2(MAX_JOBS)-1:0]          rd_idx,
  input  wire logic                                 clear,
  output logic [TIME_BITS-1:0]                      rd_s,
  output logic [TIME_BITS-1:0]                      rd_e,
  output logic [iog_pkg::IDX_W-1:0]                 rd_i,
  output logic [$clog2(MAX_JOBS+1)-1:0]             count,
  output logic                                      ovf,
  output logic                                      done
);
  import iog_pkg::*;
  localparam int unsigned CW = $clog2(MAX_JOBS+1);

  logic [TIME_BITS-1:0] s_r [MAX_JOBS];
  logic [TIME_BITS-1:0] e_r [MAX_JOBS];
  logic [IDX_W-1:0]     i_r [MAX_JOBS];
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt, done_r, done_nxt;
  logic [MAX_JOBS-1:0]  gt;
  logic [MAX_JOBS-1:0]  gt_below;
  logic                 room;

  assign room = (cnt_r < CW'(MAX_JOBS));

  // Each cell compares itself to the new start; cells above the insert point shift up.
  always_comb begin
    for (int k = 0; k < MAX_JOBS; k++) begin
      gt[k] = (CW'(k) < cnt_r) && (s_r[k] > s_in);
    end
  end

  // Bit k tells whether the cell below cell k moves up.
  assign gt_below = {gt[MAX_JOBS-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (push && room) begin
      for (int k = 0; k < MAX_JOBS; k++) begin
        if (gt_below[k]) begin
          s_r[k] <= s_r[k-1];
          e_r[k] <= e_r[k-1];
          i_r[k] <= i_r[k-1];
        end else if (gt[k] || CW'(k) == cnt_r) begin
          s_r[k] <= s_in;
          e_r[k] <= e_in;
          i_r[k] <= cnt_r[IDX_W-1:0];
        end
      end
    end
    if (rd_en) begin
      rd_s <= s_r[rd_idx];
      rd_e <= e_r[rd_idx];
      rd_i <= i_r[rd_idx];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    done_nxt = done_r;
    if (clear) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
      done_nxt = 1'b0;
    end else if (push) begin
      if (room) cnt_nxt = cnt_r + CW'(1);
      else ovf_nxt = 1'b1;
      done_nxt = last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      done_r <= done_nxt;
    end
  end

  assign count = cnt_r;
  assign ovf = ovf_r;
  assign done = done_r;
endmodule
`default_nettype wire

// ===== rtl/core/iog_back.sv =====
// Back end: walks the ordered list, keeps the running group end and emits one result a cycle.
// Depends on iog_pkg and reads entries from iog_front.
`default_nettype none
module iog_back #(
  parameter int unsigned MAX_JOBS = 32,
  parameter int unsigned TIME_BITS = 40
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             go,
  input  wire logic [$clog2(MAX_JOBS+1)-1:0]    count,
  input  wire logic                             ovf,
  input  wire logic [TIME_BITS-1:0]             rd_s,
  input  wire logic [TIME_BITS-1:0]             rd_e,
  input  wire logic [iog_pkg::IDX_W-1:0]        rd_i,
  output logic                                  rd_en,
  output logic [$clog2(MAX_JOBS)-1:0]           rd_idx,
  output logic                                  clear,
  output logic                                  active,
  output logic                                  out_valid,
  output logic [iog_pkg::IDX_W-1:0]             out_arrival_index,
  output logic [iog_pkg::FIELD_W-1:0]           out_sorted_start,
  output logic [iog_pkg::FIELD_W-1:0]           out_sorted_end,
  output logic [iog_pkg::IDX_W-1:0]             out_group_number,
  output logic                                  out_opens_group,
  output logic                                  out_truncated,
  output logic                                  out_last_result
);
  import iog_pkg::*;
  localparam int unsigned AW = $clog2(MAX_JOBS);
  localparam int unsigned CW = $clog2(MAX_JOBS+1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           st_r, st_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [TIME_BITS-1:0] run_r, run_nxt;
  logic [IDX_W-1:0]     grp_r, grp_nxt;
  logic                 v_r, v_nxt, opens, lastk;
  logic [IDX_W-1:0]     ai_r, g_r;
  logic [TIME_BITS-1:0] os_r, oe_r;
  logic                 op_r, tr_r, lr_r;

  // A data word arrives the cycle after its read; k_r tracks which entry it is.
  assign rd_en = (st_r != ST_IDLE);
  assign rd_idx = k_nxt[AW-1:0];
  assign opens = (k_r == '0) || (rd_s >= run_r);
  assign lastk = (k_r + CW'(1) == count);
  assign active = (st_r != ST_IDLE);
  assign clear = (st_r == ST_EMIT) && lastk;

  always_comb begin
    st_nxt = st_r;
    k_nxt = k_r;
    run_nxt = run_r;
    grp_nxt = grp_r;
    v_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (go) st_nxt = (count == '0) ? ST_IDLE : ST_READ;
      end
      ST_READ: st_nxt = ST_EMIT;
      ST_EMIT: begin
        v_nxt = 1'b1;
        if (opens) begin
          run_nxt = rd_e;
          grp_nxt = (k_r == '0) ? '0 : grp_r + IDX_W'(1);
        end else if (rd_e > run_r) begin
          run_nxt = rd_e;
        end
        if (lastk) begin
          st_nxt = ST_IDLE;
          k_nxt = '0;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      v_r <= 1'b0;
      k_r <= '0;
    end else begin
      st_r <= st_nxt;
      v_r <= v_nxt;
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    grp_r <= grp_nxt;
    if (st_r == ST_EMIT) begin
      ai_r <= rd_i;
      os_r <= rd_s;
      oe_r <= rd_e;
      g_r <= grp_nxt;
      op_r <= opens;
      tr_r <= ovf;
      lr_r <= lastk;
    end
  end

  assign out_valid = v_r;
  assign out_arrival_index = ai_r;
  assign out_sorted_start = FIELD_W'(os_r);
  assign out_sorted_end = FIELD_W'(oe_r);
  assign out_group_number = g_r;
  assign out_opens_group = op_r;
  assign out_truncated = tr_r;
  assign out_last_result = lr_r;
endmodule
`default_nettype wire

// ===== rtl/core/interval_overlap_grouper.sv =====
// Interval overlap grouper top level: a sorting front end and a grouping back end.
// Depends on iog_pkg, iog_front and iog_back.
// An interval is taken every cycle while busy is low and drops into sorted place
// in the insertion chain in that cycle. The word marked last starts the walk:
// the back end leaves idle, reads the first entry and groups it into a registered
// result, then results follow one per cycle, N in all. busy is high from the
// cycle after the last word until the cycle that carries the last result. The
// receiver cannot stall; out_valid marks each result for one cycle. Items beyond
// MAX_JOBS are dropped and flag truncated.
`default_nettype none
module interval_overlap_grouper #(
  parameter int unsigned MAX_JOBS = 32,
  parameter int unsigned TIME_BITS = 40
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [iog_pkg::FIELD_W-1:0]  in_start_time,
  input  wire logic [iog_pkg::FIELD_W-1:0]  in_end_time,
  input  wire logic                         in_last_item,
  output logic                              out_valid,
  output logic [iog_pkg::IDX_W-1:0]         out_arrival_index,
  output logic [iog_pkg::FIELD_W-1:0]       out_sorted_start,
  output logic [iog_pkg::FIELD_W-1:0]       out_sorted_end,
  output logic [iog_pkg::IDX_W-1:0]         out_group_number,
  output logic                              out_opens_group,
  output logic                              out_truncated,
  output logic                              out_last_result
);
  import iog_pkg::*;
  localparam int unsigned AW = $clog2(MAX_JOBS);
  localparam int unsigned CW = $clog2(MAX_JOBS+1);

  logic push, rd_en, clear, ovf, done, active;
  logic [AW-1:0] rd_idx;
  logic [CW-1:0] count;
  logic [TIME_BITS-1:0] rd_s, rd_e, s_in, e_in;
  logic [IDX_W-1:0] rd_i;

  assign push = start && !busy;
  assign busy = done || active;
  assign s_in = TIME_BITS'(in_start_time);
  assign e_in = TIME_BITS'(in_end_time);

  iog_front #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .s_in(s_in), .e_in(e_in),
    .last_in(in_last_item), .rd_en(rd_en), .rd_idx(rd_idx), .clear(clear),
    .rd_s(rd_s), .rd_e(rd_e), .rd_i(rd_i), .count(count), .ovf(ovf), .done(done)
  );

  iog_back #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .go(done && !active), .count(count), .ovf(ovf),
    .rd_s(rd_s), .rd_e(rd_e), .rd_i(rd_i), .rd_en(rd_en), .rd_idx(rd_idx),
    .clear(clear), .active(active), .out_valid(out_valid),
    .out_arrival_index(out_arrival_index), .out_sorted_start(out_sorted_start),
    .out_sorted_end(out_sorted_end), .out_group_number(out_group_number),
    .out_opens_group(out_opens_group), .out_truncated(out_truncated),
    .out_last_result(out_last_result)
  );
endmodule
`default_nettype wire

// ===== verif/interval_overlap_grouper_tb.sv =====
// Testbench for interval_overlap_grouper: drives batches of intervals and checks
// every sorted, grouped result against a predictor kept in a scoreboard class.
// Depends on iog_pkg and the interval_overlap_grouper RTL.
`timescale 1ns / 100ps

class group_scoreboard;
  localparam int CAP = 32;
  logic [39:0] st_q[$];
  logic [39:0] en_q[$];
  logic [4:0] idx_q[$];
  bit dropped;
  logic [92:0] expected_q[$];
  int errors;
  int results_seen;
  int batches;

  function new();
    errors = 0;
    results_seen = 0;
    batches = 0;
    dropped = 0;
  endfunction

  // Notes one accepted word; the word marked last builds the batch's results.
  function void note_interval(logic [39:0] s, logic [39:0] e, bit last);
    int pos;
    int n;
    logic [39:0] run_end;
    logic [4:0] grp;
    bit opens;
    if (st_q.size() < CAP) begin
      pos = st_q.size();
      while (pos > 0 && st_q[pos-1] > s) pos--;
      st_q.insert(pos, s);
      en_q.insert(pos, e);
      idx_q.insert(pos, 5'(st_q.size() - 1));
    end else begin
      dropped = 1;
    end
    if (!last) return;
    n = st_q.size();
    run_end = '0;
    grp = '0;
    for (int k = 0; k < n; k++) begin
      if (k == 0) begin
        opens = 1;
        run_end = en_q[0];
      end else if (st_q[k] >= run_end) begin
        opens = 1;
        grp++;
        run_end = en_q[k];
      end else begin
        opens = 0;
        if (en_q[k] > run_end) run_end = en_q[k];
      end
      expected_q.insert(expected_q.size(), {idx_q[k], st_q[k], en_q[k], grp, opens,
                                            dropped, bit'(k == n - 1)});
    end
    st_q.delete();
    en_q.delete();
    idx_q.delete();
    dropped = 0;
    batches++;
  endfunction

  function void check_result(logic [92:0] got, realtime t);
    logic [92:0] want;
    results_seen++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result %h", t, got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (want[92:88] !== got[92:88])
      $display("%0t: arrival_index expected %0d actual %0d", t, want[92:88], got[92:88]);
    if (want[87:48] !== got[87:48])
      $display("%0t: sorted_start expected %h actual %h", t, want[87:48], got[87:48]);
    if (want[47:8] !== got[47:8])
      $display("%0t: sorted_end expected %h actual %h", t, want[47:8], got[47:8]);
    if (want[7:3] !== got[7:3])
      $display("%0t: group_number expected %0d actual %0d", t, want[7:3], got[7:3]);
    if (want[2] !== got[2])
      $display("%0t: opens_group expected %b actual %b", t, want[2], got[2]);
    if (want[1] !== got[1])
      $display("%0t: truncated expected %b actual %b", t, want[1], got[1]);
    if (want[0] !== got[0])
      $display("%0t: last_result expected %b actual %b", t, want[0], got[0]);
    if (want !== got) errors++;
  endfunction
endclass

module interval_overlap_grouper_tb;
  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [39:0] in_start_time;
  logic [39:0] in_end_time;
  logic in_last_item;
  logic out_valid;
  logic [4:0] out_arrival_index;
  logic [39:0] out_sorted_start;
  logic [39:0] out_sorted_end;
  logic [4:0] out_group_number;
  logic out_opens_group;
  logic out_truncated;
  logic out_last_result;

  group_scoreboard sb;
  int cycle_count;
  int words_sent;
  bit calm;

  interval_overlap_grouper u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_time(in_start_time), .in_end_time(in_end_time),
    .in_last_item(in_last_item), .out_valid(out_valid),
    .out_arrival_index(out_arrival_index), .out_sorted_start(out_sorted_start),
    .out_sorted_end(out_sorted_end), .out_group_number(out_group_number),
    .out_opens_group(out_opens_group), .out_truncated(out_truncated),
    .out_last_result(out_last_result)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Results cannot be held off, so every strobed cycle is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_arrival_index, out_sorted_start, out_sorted_end,
                       out_group_number, out_opens_group, out_truncated,
                       out_last_result}, $realtime);
  end

  // start is left high after the word goes in, so words can follow back to back;
  // callers drop it when they stop sending.
  task automatic send_word(logic [39:0] s, logic [39:0] e, bit last);
    while (!calm && $urandom_range(99) < 32) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_start_time <= s;
    in_end_time <= e;
    in_last_item <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_interval(s, e, last);
    words_sent++;
  endtask

  function automatic logic [39:0] rand_time(int mode);
    case (mode)
      0: return 40'($urandom_range(63));
      1: return {8'($urandom), 32'($urandom)};
      default: return 40'($urandom_range(2000));
    endcase
  endfunction

  task automatic send_batch(int n, int mode);
    logic [39:0] s;
    for (int i = 0; i < n; i++) begin
      s = rand_time(mode);
      send_word(s, (mode == 1) ? rand_time(1) : s + 40'($urandom_range(40)),
                i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    start = 0;
    in_start_time = '0;
    in_end_time = '0;
    in_last_item = 0;
    words_sent = 0;
    calm = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: a single word, extremes, ties, touching ends, end before start.
    send_word('0, '1, 1);
    send_word('1, '0, 1);
    send_word(40'd10, 40'd20, 0);
    send_word(40'd10, 40'd5, 0);
    send_word(40'd20, 40'd30, 0);
    send_word(40'd0, 40'd10, 1);
    send_word(40'd5, 40'd5, 0);
    send_word(40'd5, 40'd5, 1);
    // Over capacity, and a dropped word that carries the last mark.
    send_batch(34, 0);
    start <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    for (int b = 0; b < 6; b++) begin
      calm = (b >= 2 && b < 4);
      send_batch($urandom_range(1, 12), $urandom_range(2));
    end
    calm = 0;
    send_batch(20, 1);
    start <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d words in %0d batches and checked %0d results.",
             words_sent, sb.batches, sb.results_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/iog_pkg.sv
rtl/core/iog_front.sv
rtl/core/iog_back.sv
rtl/core/interval_overlap_grouper.sv
verif/interval_overlap_grouper_tb.sv
